// File: hdl/ptcp_pkg.sv
// shared constants, types and tile functions for the pipe tile constraint propagator
package ptcp_pkg;

	localparam int MAX_SIDE = 64;
	localparam int COORD_W = $clog2(MAX_SIDE);
	localparam int ADDR_W = 2 * COORD_W;
	localparam int CELLS = MAX_SIDE * MAX_SIDE;
	localparam int COUNT_W = ADDR_W + 1;
	localparam int SIDE_W = 7;
	localparam int PCT_W = 7;
	localparam int MASK_W = 16;
	localparam int TILE_W = 4;
	localparam int OPTCNT_W = 5;

	localparam logic [OPTCNT_W-1:0] NONE_COUNT = 5'd17;
	localparam logic [PCT_W-1:0] FULL_PERCENT = 7'd100;
	localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd8;
	localparam logic [PCT_W-1:0] PCT_RESET = 7'd50;
	localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

	// tile 0 and the tiles with two or more exits
	localparam logic [MASK_W-1:0] EMPTY_TILE = 16'h0001;
	localparam logic [MASK_W-1:0] MULTI_EXIT = 16'hFEE8;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_COLLAPSE = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [1:0] DIR_UP = 2'd0;
	localparam logic [1:0] DIR_DOWN = 2'd1;
	localparam logic [1:0] DIR_LEFT = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	localparam logic REG_GRID_SIDE = 1'b0;
	localparam logic REG_PIPE_PCT = 1'b1;

	typedef enum logic [4:0] {
		ST_CLR,
		ST_IDLE,
		ST_FILL,
		ST_PUSH,
		ST_POP,
		ST_POP_W,
		ST_CUR_W,
		ST_NB,
		ST_NB_EV,
		ST_DRAIN,
		ST_DRAIN_W,
		ST_COL_RD,
		ST_COL_EV,
		ST_FIN_RD,
		ST_FIN_W,
		ST_SCAN,
		ST_SCAN_END,
		ST_DONE
	} ptcp_state_t;

	function automatic logic [MASK_W-1:0] exit_mask(input logic [1:0] d);
		logic [MASK_W-1:0] m;
		case (d)
			DIR_UP:    m = 16'hAAAA;
			DIR_DOWN:  m = 16'hCCCC;
			DIR_LEFT:  m = 16'hF0F0;
			DIR_RIGHT: m = 16'hFF00;
			default:   m = 16'hFF00;
		endcase
		return m;
	endfunction

	function automatic logic [MASK_W-1:0] entry_mask(input logic [1:0] d);
		logic [MASK_W-1:0] m;
		case (d)
			DIR_UP:    m = 16'hCCCC;
			DIR_DOWN:  m = 16'hAAAA;
			DIR_LEFT:  m = 16'hFF00;
			DIR_RIGHT: m = 16'hF0F0;
			default:   m = 16'hF0F0;
		endcase
		return m;
	endfunction

	// tiles a neighbor may keep given this cell's options
	function automatic logic [MASK_W-1:0] allowed_next(input logic [MASK_W-1:0] m,
			input logic [1:0] d);
		logic [MASK_W-1:0] ex;
		logic [MASK_W-1:0] en;
		logic [MASK_W-1:0] res;
		ex = exit_mask(d);
		en = entry_mask(d);
		res = '0;
		if (|(m & ex)) res = res | en;
		if (|(m & ~ex)) res = res | ~en;
		return res;
	endfunction

	function automatic logic [OPTCNT_W-1:0] popcount16(input logic [MASK_W-1:0] m);
		logic [OPTCNT_W-1:0] n;
		n = '0;
		for (int t = 0; t < MASK_W; t++) n = n + OPTCNT_W'(m[t]);
		return n;
	endfunction

endpackage

// File: hdl/pipe_tile_constraint_propagator.sv
// pipe tile constraint propagator: option store, work queue and command sequencer
//
// channel   signals                                   direction
// command   start busy command cell_row cell_col      in (busy out)
//           tile_code
// result    done cell_options status best_row         out
//           best_col next_count
// config    psel penable pwrite paddr pwdata prdata   apb
//           pready
//
// after reset the pending-mark memory is swept while busy is high
// start: fill every cell and queue every cell, then propagate from each queued cell
// collapse: narrow the cell, propagate from each queued cell, then fetch the mask; read: fetch the mask
// every command ends with a scan for the fewest-options cell
// the 1R1W option memory sets the pace; done strobes for one cycle, never held off
module pipe_tile_constraint_propagator (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] command,
	input  logic [5:0] cell_row,
	input  logic [5:0] cell_col,
	input  logic [3:0] tile_code,
	output logic done,
	output logic [15:0] cell_options,
	output logic status,
	output logic [5:0] best_row,
	output logic [5:0] best_col,
	output logic [4:0] next_count,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int AW = ptcp_pkg::ADDR_W;
	localparam int CW = ptcp_pkg::COORD_W;
	localparam int MW = ptcp_pkg::MASK_W;

	// memories
	logic [MW-1:0] opt_mem [ptcp_pkg::CELLS];
	logic [AW-1:0] queue_mem [ptcp_pkg::CELLS];
	logic pend_mem [ptcp_pkg::CELLS];

	logic opt_we;
	logic [AW-1:0] opt_wa, opt_ra;
	logic [MW-1:0] opt_wd, opt_rd_q;
	logic q_we;
	logic [AW-1:0] q_wa, q_wd, q_ra, q_rd_q;
	logic pend_we, pend_wd, pend_rd_q;
	logic [AW-1:0] pend_wa, pend_ra;

	ptcp_pkg::ptcp_state_t state_q, state_d;

	logic [ptcp_pkg::SIDE_W-1:0] grid_side_q;
	logic [ptcp_pkg::PCT_W-1:0] pipe_percent_q;
	logic [1:0] cmd_q;
	logic [CW-1:0] row_q, col_q;
	logic [3:0] tile_q;
	logic [CW-1:0] side_m1_q;
	logic flag_q;
	logic [CW-1:0] r_q, c_q;
	logic [AW-1:0] head_q, tail_q;
	logic [ptcp_pkg::COUNT_W-1:0] count_q;
	logic [AW-1:0] cur_q;
	logic [MW-1:0] cur_mask_q;
	logic [1:0] dir_q;
	logic [MW-1:0] opts_q;
	logic [ptcp_pkg::OPTCNT_W-1:0] best_q;
	logic [CW-1:0] br_q, bc_q;
	logic scan_vld_s1;
	logic [CW-1:0] scan_r_s1, scan_c_s1;

	logic accept;
	logic [ptcp_pkg::SIDE_W-1:0] side_clip;
	logic [CW-1:0] side_m1;
	logic in_grid;
	logic [AW-1:0] idx, rc_addr;
	logic last_cell;
	logic [MW-1:0] init_mask, fill_mask;
	logic nb_ok;
	logic [CW-1:0] cur_r, cur_c, nb_r, nb_c;
	logic [AW-1:0] nb_addr;
	logic [MW-1:0] nb_new, col_new;
	logic pop_en;
	logic [ptcp_pkg::OPTCNT_W-1:0] scan_n;

	assign accept = start && !busy;
	assign busy = (state_q != ptcp_pkg::ST_IDLE);

	// configuration port
	assign pready = 1'b1;
	always_comb begin
		if (paddr[2] == ptcp_pkg::REG_PIPE_PCT) begin
			prdata = {25'd0, pipe_percent_q};
		end else begin
			prdata = {25'd0, grid_side_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= ptcp_pkg::SIDE_RESET;
			pipe_percent_q <= ptcp_pkg::PCT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == ptcp_pkg::REG_PIPE_PCT) begin
				pipe_percent_q <= pwdata[6:0];
			end else begin
				grid_side_q <= pwdata[6:0];
			end
		end
	end

	always_comb begin
		if (grid_side_q == '0) begin
			side_clip = 7'd1;
		end else if (grid_side_q > ptcp_pkg::SIDE_MAX) begin
			side_clip = ptcp_pkg::SIDE_MAX;
		end else begin
			side_clip = grid_side_q;
		end
	end
	assign side_m1 = CW'(side_clip - 7'd1);
	assign in_grid = ({1'b0, cell_row} < side_clip) && ({1'b0, cell_col} < side_clip);

	assign idx = {row_q, col_q};
	assign rc_addr = {r_q, c_q};
	assign last_cell = (r_q == side_m1_q) && (c_q == side_m1_q);

	always_comb begin
		init_mask = '0;
		if (pipe_percent_q < ptcp_pkg::FULL_PERCENT) init_mask = init_mask | ptcp_pkg::EMPTY_TILE;
		if (pipe_percent_q != '0) init_mask = init_mask | ptcp_pkg::MULTI_EXIT;
		fill_mask = init_mask;
		if (r_q == '0) fill_mask = fill_mask & ~ptcp_pkg::exit_mask(ptcp_pkg::DIR_UP);
		if (r_q == side_m1_q) fill_mask = fill_mask & ~ptcp_pkg::exit_mask(ptcp_pkg::DIR_DOWN);
		if (c_q == '0) fill_mask = fill_mask & ~ptcp_pkg::exit_mask(ptcp_pkg::DIR_LEFT);
		if (c_q == side_m1_q) fill_mask = fill_mask & ~ptcp_pkg::exit_mask(ptcp_pkg::DIR_RIGHT);
	end

	// neighbor of the current cell in direction dir_q
	assign cur_r = cur_q[AW-1:CW];
	assign cur_c = cur_q[CW-1:0];
	always_comb begin
		nb_r = cur_r;
		nb_c = cur_c;
		nb_ok = 1'b0;
		case (dir_q)
			ptcp_pkg::DIR_UP: begin
				nb_ok = (cur_r != '0);
				nb_r = cur_r - CW'(1);
			end
			ptcp_pkg::DIR_DOWN: begin
				nb_ok = (cur_r != side_m1_q);
				nb_r = cur_r + CW'(1);
			end
			ptcp_pkg::DIR_LEFT: begin
				nb_ok = (cur_c != '0);
				nb_c = cur_c - CW'(1);
			end
			default: begin
				nb_ok = (cur_c != side_m1_q);
				nb_c = cur_c + CW'(1);
			end
		endcase
	end
	assign nb_addr = {nb_r, nb_c};
	assign nb_new = opt_rd_q & ptcp_pkg::allowed_next(cur_mask_q, dir_q);
	assign col_new = opt_rd_q & (MW'(1) << tile_q);
	assign pop_en = ((state_q == ptcp_pkg::ST_POP) || (state_q == ptcp_pkg::ST_DRAIN))
		&& (count_q != '0);
	assign scan_n = ptcp_pkg::popcount16(opt_rd_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptcp_pkg::ST_CLR: begin
				if (rc_addr == '1) state_d = ptcp_pkg::ST_IDLE;
			end
			ptcp_pkg::ST_IDLE: begin
				if (accept) begin
					case (command)
						ptcp_pkg::CMD_START: state_d = ptcp_pkg::ST_FILL;
						ptcp_pkg::CMD_COLLAPSE:
							state_d = in_grid ? ptcp_pkg::ST_COL_RD : ptcp_pkg::ST_SCAN;
						ptcp_pkg::CMD_READ:
							state_d = in_grid ? ptcp_pkg::ST_FIN_RD : ptcp_pkg::ST_SCAN;
						default: state_d = ptcp_pkg::ST_SCAN;
					endcase
				end
			end
			ptcp_pkg::ST_FILL: begin
				if (last_cell) begin
					state_d = (flag_q || fill_mask == '0) ? ptcp_pkg::ST_SCAN : ptcp_pkg::ST_PUSH;
				end
			end
			ptcp_pkg::ST_PUSH: begin
				if (last_cell) state_d = ptcp_pkg::ST_POP;
			end
			ptcp_pkg::ST_POP: begin
				if (count_q == '0) begin
					state_d = (cmd_q == ptcp_pkg::CMD_COLLAPSE) ? ptcp_pkg::ST_FIN_RD
						: ptcp_pkg::ST_SCAN;
				end else begin
					state_d = ptcp_pkg::ST_POP_W;
				end
			end
			ptcp_pkg::ST_POP_W: state_d = ptcp_pkg::ST_CUR_W;
			ptcp_pkg::ST_CUR_W: state_d = ptcp_pkg::ST_NB;
			ptcp_pkg::ST_NB: begin
				if (nb_ok) begin
					state_d = ptcp_pkg::ST_NB_EV;
				end else if (dir_q == ptcp_pkg::DIR_RIGHT) begin
					state_d = ptcp_pkg::ST_POP;
				end
			end
			ptcp_pkg::ST_NB_EV: begin
				if (nb_new == '0) begin
					state_d = ptcp_pkg::ST_DRAIN;
				end else if (dir_q == ptcp_pkg::DIR_RIGHT) begin
					state_d = ptcp_pkg::ST_POP;
				end else begin
					state_d = ptcp_pkg::ST_NB;
				end
			end
			ptcp_pkg::ST_DRAIN: begin
				if (count_q == '0) begin
					state_d = (cmd_q == ptcp_pkg::CMD_COLLAPSE) ? ptcp_pkg::ST_FIN_RD
						: ptcp_pkg::ST_SCAN;
				end else begin
					state_d = ptcp_pkg::ST_DRAIN_W;
				end
			end
			ptcp_pkg::ST_DRAIN_W: state_d = ptcp_pkg::ST_DRAIN;
			ptcp_pkg::ST_COL_RD: state_d = ptcp_pkg::ST_COL_EV;
			ptcp_pkg::ST_COL_EV: begin
				state_d = (col_new == '0) ? ptcp_pkg::ST_FIN_RD : ptcp_pkg::ST_POP;
			end
			ptcp_pkg::ST_FIN_RD: state_d = ptcp_pkg::ST_FIN_W;
			ptcp_pkg::ST_FIN_W: state_d = ptcp_pkg::ST_SCAN;
			ptcp_pkg::ST_SCAN: begin
				if (last_cell) state_d = ptcp_pkg::ST_SCAN_END;
			end
			ptcp_pkg::ST_SCAN_END: state_d = ptcp_pkg::ST_DONE;
			ptcp_pkg::ST_DONE: state_d = ptcp_pkg::ST_IDLE;
			default: state_d = ptcp_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		opt_we = 1'b0;
		opt_wa = idx;
		opt_wd = col_new;
		opt_ra = idx;
		q_we = 1'b0;
		q_wa = tail_q;
		q_wd = idx;
		q_ra = head_q;
		pend_we = 1'b0;
		pend_wa = idx;
		pend_wd = 1'b0;
		pend_ra = nb_addr;
		case (state_q)
			ptcp_pkg::ST_CLR: begin
				pend_we = 1'b1;
				pend_wa = rc_addr;
			end
			ptcp_pkg::ST_FILL: begin
				opt_we = 1'b1;
				opt_wa = rc_addr;
				opt_wd = fill_mask;
			end
			ptcp_pkg::ST_PUSH: begin
				q_we = 1'b1;
				q_wd = rc_addr;
				pend_we = 1'b1;
				pend_wa = rc_addr;
				pend_wd = 1'b1;
			end
			ptcp_pkg::ST_POP_W: begin
				opt_ra = q_rd_q;
				pend_we = 1'b1;
				pend_wa = q_rd_q;
			end
			ptcp_pkg::ST_NB: begin
				opt_ra = nb_addr;
			end
			ptcp_pkg::ST_NB_EV: begin
				if (nb_new != '0 && nb_new != opt_rd_q) begin
					opt_we = 1'b1;
					opt_wa = nb_addr;
					opt_wd = nb_new;
					if (!pend_rd_q) begin
						q_we = 1'b1;
						q_wd = nb_addr;
						pend_we = 1'b1;
						pend_wa = nb_addr;
						pend_wd = 1'b1;
					end
				end
			end
			ptcp_pkg::ST_DRAIN_W: begin
				pend_we = 1'b1;
				pend_wa = q_rd_q;
			end
			ptcp_pkg::ST_COL_EV: begin
				opt_we = 1'b1;
				if (col_new != '0) begin
					q_we = 1'b1;
					pend_we = 1'b1;
					pend_wd = 1'b1;
				end
			end
			ptcp_pkg::ST_SCAN: begin
				opt_ra = rc_addr;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (opt_we) opt_mem[opt_wa] <= opt_wd;
		opt_rd_q <= opt_mem[opt_ra];
		if (q_we) queue_mem[q_wa] <= q_wd;
		q_rd_q <= queue_mem[q_ra];
		if (pend_we) pend_mem[pend_wa] <= pend_wd;
		pend_rd_q <= pend_mem[pend_ra];
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptcp_pkg::ST_CLR;
			flag_q <= 1'b0;
			r_q <= '0;
			c_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			dir_q <= '0;
			scan_vld_s1 <= 1'b0;
			best_q <= ptcp_pkg::NONE_COUNT;
			br_q <= '0;
			bc_q <= '0;
		end else begin
			state_q <= state_d;
			scan_vld_s1 <= (state_q == ptcp_pkg::ST_SCAN);
			if (q_we) tail_q <= tail_q + AW'(1);
			if (pop_en) head_q <= head_q + AW'(1);
			count_q <= count_q + ptcp_pkg::COUNT_W'(q_we) - ptcp_pkg::COUNT_W'(pop_en);

			case (state_q)
				ptcp_pkg::ST_CLR: {r_q, c_q} <= rc_addr + AW'(1);
				ptcp_pkg::ST_IDLE: begin
					if (accept) begin
						r_q <= '0;
						c_q <= '0;
						best_q <= ptcp_pkg::NONE_COUNT;
						if (command == ptcp_pkg::CMD_START) flag_q <= 1'b0;
					end
				end
				ptcp_pkg::ST_FILL, ptcp_pkg::ST_PUSH, ptcp_pkg::ST_SCAN: begin
					if (state_q == ptcp_pkg::ST_FILL && fill_mask == '0) flag_q <= 1'b1;
					// each grid walk leaves the position at the first cell
					if (last_cell) begin
						r_q <= '0;
						c_q <= '0;
					end else if (c_q == side_m1_q) begin
						c_q <= '0;
						r_q <= r_q + CW'(1);
					end else begin
						c_q <= c_q + CW'(1);
					end
				end
				ptcp_pkg::ST_POP_W: dir_q <= ptcp_pkg::DIR_UP;
				ptcp_pkg::ST_NB: begin
					if (!nb_ok) dir_q <= dir_q + 2'd1;
				end
				ptcp_pkg::ST_NB_EV: begin
					if (nb_new == '0) begin
						flag_q <= 1'b1;
					end else begin
						dir_q <= dir_q + 2'd1;
					end
				end
				ptcp_pkg::ST_COL_EV: begin
					if (col_new == '0) flag_q <= 1'b1;
				end
				default: begin
				end
			endcase

			// fewest options above one, first in row-major order
			if (scan_vld_s1 && scan_n > 5'd1 && scan_n < best_q) begin
				best_q <= scan_n;
				br_q <= scan_r_s1;
				bc_q <= scan_c_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		scan_r_s1 <= r_q;
		scan_c_s1 <= c_q;
		if (state_q == ptcp_pkg::ST_POP_W) cur_q <= q_rd_q;
		if (state_q == ptcp_pkg::ST_CUR_W) cur_mask_q <= opt_rd_q;
		if (state_q == ptcp_pkg::ST_FIN_W) opts_q <= opt_rd_q;
		if (accept) begin
			cmd_q <= command;
			row_q <= cell_row;
			col_q <= cell_col;
			tile_q <= tile_code;
			side_m1_q <= side_m1;
			opts_q <= '0;
		end
	end

	// result word
	assign done = (state_q == ptcp_pkg::ST_DONE);
	assign cell_options = opts_q;
	assign status = flag_q;
	always_comb begin
		if (best_q == ptcp_pkg::NONE_COUNT) begin
			next_count = '0;
			best_row = '0;
			best_col = '0;
		end else begin
			next_count = best_q;
			best_row = br_q;
			best_col = bc_q;
		end
	end

endmodule
